FILE: design/clnw_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD nibble writer package
// Shared types, constants and lookup functions for the 4-bit LCD writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

	// Column count after which the second-row address is sent.
	localparam int WRAP_COLUMN = 16;
	localparam int CNT_W       = 6;
	localparam logic [CNT_W-1:0] WRAP_CNT = CNT_W'(WRAP_COLUMN);

	// Field widths.
	localparam int CMD_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int NIB_W   = 4;
	localparam int WAIT_W  = 16;
	localparam int PW_W    = 10;
	localparam int HOLD_W  = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_WAIT = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [PW_W-1:0]   PULSE_WIDTH_RST = 10'd25;
	localparam logic [WAIT_W-1:0] SETTLE_WAIT_RST = 16'd1000;

	// Input command codes.
	localparam logic [CMD_W-1:0] CMD_INSTR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

	// Fixed bytes and waits.
	localparam logic [BYTE_W-1:0] ROW2_ADDR    = 8'hC0;
	localparam logic [HOLD_W-1:0] POWERUP_WAIT = 17'd3200;
	localparam int INIT_LEN   = 9;
	localparam int INIT_IDX_W = 4;
	localparam logic [INIT_IDX_W-1:0] LAST_INIT_IDX = INIT_IDX_W'(INIT_LEN - 1);

	// Work handed from the front to the back.
	typedef enum logic [1:0] {
		JOB_INSTR     = 2'd0,
		JOB_DATA      = 2'd1,
		JOB_DATA_WRAP = 2'd2,
		JOB_INIT      = 2'd3
	} job_op_t;

	typedef struct packed {
		job_op_t             op;
		logic [BYTE_W-1:0]   value;
		logic [WAIT_W-1:0]   post_wait;
	} job_t;

	// Configuration seen by the back end.
	typedef struct packed {
		logic [PW_W-1:0]   pulse_width;
		logic [WAIT_W-1:0] settle_wait;
	} cfg_t;

	// Instruction bytes of the power-up sequence.
	function automatic logic [BYTE_W-1:0] init_byte(input logic [INIT_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		case (idx)
			4'd0:    b = 8'h30;
			4'd1:    b = 8'h30;
			4'd2:    b = 8'h30;
			4'd3:    b = 8'h20;
			4'd4:    b = 8'h28;
			4'd5:    b = 8'h0C;
			4'd6:    b = 8'h06;
			4'd7:    b = 8'h01;
			4'd8:    b = 8'h80;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Extra waits that follow each power-up instruction.
	function automatic logic [WAIT_W-1:0] init_wait(input logic [INIT_IDX_W-1:0] idx);
		logic [WAIT_W-1:0] w;
		case (idx)
			4'd0:    w = 16'd3000;
			4'd1:    w = 16'd30000;
			4'd2:    w = 16'd30000;
			4'd3:    w = 16'd30000;
			4'd4:    w = 16'd30000;
			4'd5:    w = 16'd800;
			4'd6:    w = 16'd800;
			4'd7:    w = 16'd10000;
			4'd8:    w = 16'd800;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

endpackage

FILE: design/char_lcd_nibble_writer_unit.sv
// ----------------------------------------------------------------------------
// Character LCD nibble writer
// Expands instruction, data and init items into 4-bit LCD pin steps.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_stall   | command, value, post_wait
//   out     | out_valid / out_stall | lcd_data, reg_select, enable, hold, last
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// The back end emits one pin step per cycle unless out stalls: 4 for a byte,
// 8 for a data byte that wraps, 37 for init, so that step sequencer sets the item rate.
// The front takes one item per cycle while the two-entry job queue has room.
// Reset clears the character count, empties the queue, and loads the default
// pulse width (25) and settle wait (1000). A stall on out holds the sequencer.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit
	import clnw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      command,
	input  logic [BYTE_W-1:0]     value,
	input  logic [WAIT_W-1:0]     post_wait,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NIB_W-1:0]      lcd_data,
	output logic                  reg_select,
	output logic                  enable,
	output logic [HOLD_W-1:0]     hold,
	output logic                  last
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	job_t q_push_job;
	logic q_pop;
	logic q_valid;
	job_t q_pop_job;

	// Configuration registers; writes to other indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_width <= PULSE_WIDTH_RST;
			cfg_q.settle_wait <= SETTLE_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PULSE_WIDTH: cfg_q.pulse_width <= cfg_data[PW_W-1:0];
				REG_SETTLE_WAIT: cfg_q.settle_wait <= cfg_data[WAIT_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	clnw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.value     (value),
		.post_wait (post_wait),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_push_job)
	);

	clnw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_job   (q_pop_job)
	);

	clnw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_job       (q_pop_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.lcd_data    (lcd_data),
		.reg_select  (reg_select),
		.enable      (enable),
		.hold        (hold),
		.last        (last)
	);

`ifndef SYNTHESIS
	// A strobe step is never the final step of an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enable |-> !last)
		else $error("enable-high step marked last");

	// A strobe step holds for the configured pulse width.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enable |-> hold == {{(HOLD_W-PW_W){1'b0}}, cfg_q.pulse_width})
		else $error("strobe hold differs from pulse width");

	// Steps of one item follow without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside an item's steps");
`endif

endmodule

FILE: design/clnw_front.sv
// ----------------------------------------------------------------------------
// LCD writer front end
// Accepts items, keeps the character count and turns each item into a job.
// ----------------------------------------------------------------------------
module clnw_front
	import clnw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [BYTE_W-1:0] value,
	input  logic [WAIT_W-1:0] post_wait,
	input  logic              q_full,
	output logic              q_push,
	output job_t              q_job
);

	logic             accept;
	logic [CNT_W-1:0] char_count_q;
	logic [CNT_W-1:0] count_inc;

	// An item is taken whenever the queue has room.
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign count_inc = char_count_q + CNT_W'(1);

	// Classify the item. The unused code is accepted and dropped.
	always_comb begin
		q_push          = 1'b0;
		q_job.op        = JOB_INSTR;
		q_job.value     = value;
		q_job.post_wait = post_wait;
		case (command)
			CMD_INSTR: begin
				q_push   = accept;
				q_job.op = JOB_INSTR;
			end
			CMD_DATA: begin
				q_push   = accept;
				q_job.op = (count_inc == WRAP_CNT) ? JOB_DATA_WRAP : JOB_DATA;
			end
			CMD_INIT: begin
				q_push   = accept;
				q_job.op = JOB_INIT;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Data bytes since the last instruction or init; a wrap, any instruction or an init clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
		end else if (accept) begin
			case (command)
				CMD_INSTR: char_count_q <= '0;
				CMD_DATA:  char_count_q <= (count_inc == WRAP_CNT) ? '0 : count_inc;
				CMD_INIT:  char_count_q <= '0;
				default:   char_count_q <= char_count_q;
			endcase
		end
	end

endmodule

FILE: design/clnw_queue.sv
// ----------------------------------------------------------------------------
// LCD writer job queue
// Two-entry queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module clnw_queue
	import clnw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_job
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_job   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/clnw_back.sv
// ----------------------------------------------------------------------------
// LCD writer back end
// Steps through each job, emitting one pin step per cycle into an output register unless out stalls.
// ----------------------------------------------------------------------------
module clnw_back
	import clnw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  job_t              q_job,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [NIB_W-1:0]  lcd_data,
	output logic              reg_select,
	output logic              enable,
	output logic [HOLD_W-1:0] hold,
	output logic              last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LEAD = 3'b010,
		ST_BYTE = 3'b100
	} back_state_t;

	back_state_t           state_q;
	job_t                  job_q;
	logic [1:0]            phase_q;
	logic [INIT_IDX_W-1:0] idx_q;

	logic                  out_valid_q;
	logic [NIB_W-1:0]      nib_q;
	logic                  rs_q;
	logic                  en_q;
	logic [HOLD_W-1:0]     hold_q;
	logic                  last_q;

	logic [BYTE_W-1:0]     cur_byte;
	logic                  cur_rs;
	logic [WAIT_W-1:0]     cur_wait;
	logic                  final_byte;
	logic [NIB_W-1:0]      step_nib;
	logic                  step_rs;
	logic                  step_en;
	logic [HOLD_W-1:0]     step_hold;
	logic                  step_last;
	logic                  adv;

	// Byte, register select and tail wait of the current byte of the job.
	always_comb begin
		cur_byte   = job_q.value;
		cur_rs     = 1'b0;
		cur_wait   = job_q.post_wait;
		final_byte = 1'b1;
		case (job_q.op)
			JOB_INSTR: begin
				cur_rs = 1'b0;
			end
			JOB_DATA: begin
				cur_rs = 1'b1;
			end
			JOB_DATA_WRAP: begin
				if (idx_q == '0) begin
					cur_rs     = 1'b1;
					final_byte = 1'b0;
				end else begin
					cur_byte = ROW2_ADDR;
					cur_wait = '0;
				end
			end
			JOB_INIT: begin
				cur_byte   = init_byte(idx_q);
				cur_wait   = init_wait(idx_q);
				final_byte = (idx_q == LAST_INIT_IDX);
			end
			default: begin
				cur_rs = 1'b0;
			end
		endcase
	end

	// Pin levels and hold of the step being produced.
	always_comb begin
		step_nib  = phase_q[1] ? cur_byte[NIB_W-1:0] : cur_byte[BYTE_W-1:NIB_W];
		step_rs   = cur_rs;
		step_en   = !phase_q[0];
		step_last = 1'b0;
		case (phase_q)
			2'd1:    step_hold = '0;
			2'd3: begin
				step_hold = {1'b0, cfg.settle_wait} + {1'b0, cur_wait};
				step_last = final_byte;
			end
			default: step_hold = {{(HOLD_W-PW_W){1'b0}}, cfg.pulse_width};
		endcase
		if (state_q == ST_LEAD) begin
			step_nib  = '0;
			step_rs   = 1'b0;
			step_en   = 1'b0;
			step_hold = POWERUP_WAIT;
			step_last = 1'b0;
		end
	end

	// A step moves whenever the output register is free or being taken.
	assign adv   = (state_q != ST_IDLE) && (!out_valid_q || !out_stall);
	assign q_pop = q_valid && ((state_q == ST_IDLE) || (adv && step_last));

	// Step sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 2'd0;
			idx_q   <= '0;
		end else if (q_pop) begin
			state_q <= (q_job.op == JOB_INIT) ? ST_LEAD : ST_BYTE;
			phase_q <= 2'd0;
			idx_q   <= '0;
		end else if (adv) begin
			case (state_q)
				ST_LEAD: begin
					state_q <= ST_BYTE;
				end
				ST_BYTE: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						if (final_byte) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + INIT_IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Job payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			nib_q  <= step_nib;
			rs_q   <= step_rs;
			en_q   <= step_en;
			hold_q <= step_hold;
			last_q <= step_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign lcd_data    = nib_q;
	assign reg_select  = rs_q;
	assign enable      = en_q;
	assign hold        = hold_q;
	assign last        = last_q;

endmodule

FILE: dv/char_lcd_nibble_writer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD nibble writer testbench
// Feeds instruction, data, init and unused-code items into the writer and
// predicts every pin step from its own copy of the column count and timing
// registers. Each step leaving the block is checked in order against the
// prediction. The run moves through several timing settings and several
// patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit_test;
	import clnw_pkg::*;

	// Code that the block takes and drops without any pin step.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Register indexes that map to nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	// Power-up instruction bytes and their extra waits, first entry leftmost.
	localparam logic [9*BYTE_W-1:0] SETUP_BYTES = {
		8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h0C, 8'h06, 8'h01, 8'h80
	};
	localparam logic [9*WAIT_W-1:0] SETUP_WAITS = {
		16'd3000, 16'd30000, 16'd30000, 16'd30000, 16'd30000,
		16'd800, 16'd800, 16'd10000, 16'd800
	};

	// Cycles allowed for the block to finish an item that makes no step.
	localparam int QUIET_CYCLES = 16;
	localparam int MAX_PRINTED  = 40;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] val;
		logic [WAIT_W-1:0] extra;
	} lcd_req_t;

	typedef struct packed {
		logic [NIB_W-1:0]  nib;
		logic              rs;
		logic              en;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} pin_step_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CMD_W-1:0]      command = '0;
	logic [BYTE_W-1:0]     value = '0;
	logic [WAIT_W-1:0]     post_wait = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [NIB_W-1:0]      lcd_data;
	logic                  reg_select;
	logic                  enable;
	logic [HOLD_W-1:0]     hold;
	logic                  last;

	// Predictor state: timing registers and the count of characters on the row.
	logic [PW_W-1:0]   pulse_w   = PULSE_WIDTH_RST;
	logic [WAIT_W-1:0] settle_w  = SETTLE_WAIT_RST;
	logic [CNT_W-1:0]  col_count = '0;

	lcd_req_t  req_q[$];
	pin_step_t pin_q[$];
	lcd_req_t  cur_req;
	int        idle_pct  = 0;
	int        stall_pct = 0;
	int        err_count = 0;

	char_lcd_nibble_writer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.post_wait   (post_wait),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.lcd_data    (lcd_data),
		.reg_select  (reg_select),
		.enable      (enable),
		.hold        (hold),
		.last        (last)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// One failure: print a line while the log is still short, and count it.
	task automatic report_error(input string msg);
		if (err_count < MAX_PRINTED)
			$display("%0t ns: %s", $time, msg);
		err_count++;
	endtask

	function automatic void push_step(input logic [NIB_W-1:0] nib, input logic rs,
			input logic en, input logic [HOLD_W-1:0] hold_units, input logic is_last);
		pin_step_t s;
		s.nib  = nib;
		s.rs   = rs;
		s.en   = en;
		s.hold = hold_units;
		s.last = is_last;
		pin_q.push_back(s);
	endfunction

	// A byte goes out as two enable pulses, high nibble first.
	function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic rs,
			input logic [WAIT_W-1:0] extra, input logic is_last);
		logic [HOLD_W-1:0] tail;
		tail = HOLD_W'(settle_w) + HOLD_W'(extra);
		push_step(b[7:4], rs, 1'b1, HOLD_W'(pulse_w), 1'b0);
		push_step(b[7:4], rs, 1'b0, '0, 1'b0);
		push_step(b[3:0], rs, 1'b1, HOLD_W'(pulse_w), 1'b0);
		push_step(b[3:0], rs, 1'b0, tail, is_last);
	endfunction

	// Expected pin steps for one accepted item.
	function automatic void expand_request(input lcd_req_t r);
		case (r.cmd)
			CMD_INSTR: begin
				push_byte(r.val, 1'b0, r.extra, 1'b1);
				col_count = '0;
			end
			CMD_DATA: begin
				col_count = col_count + 1'b1;
				if (col_count == WRAP_CNT) begin
					// The row is full, so the cursor moves to the second row.
					push_byte(r.val, 1'b1, r.extra, 1'b0);
					push_byte(ROW2_ADDR, 1'b0, '0, 1'b1);
					col_count = '0;
				end else begin
					push_byte(r.val, 1'b1, r.extra, 1'b1);
				end
			end
			CMD_INIT: begin
				push_step('0, 1'b0, 1'b0, POWERUP_WAIT, 1'b0);
				for (int i = 0; i < INIT_LEN; i++)
					push_byte(SETUP_BYTES[(INIT_LEN-1-i)*BYTE_W +: BYTE_W], 1'b0,
						SETUP_WAITS[(INIT_LEN-1-i)*WAIT_W +: WAIT_W], i == INIT_LEN - 1);
				col_count = '0;
			end
			default: begin
			end
		endcase
	endfunction

	// Driver: predict on acceptance, then present the next pending item or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expand_request(cur_req);
			if (!in_valid || !in_stall) begin
				if (req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_req = req_q.pop_front();
					in_valid  <= 1'b1;
					command   <= cur_req.cmd;
					value     <= cur_req.val;
					post_wait <= cur_req.extra;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_step();
		pin_step_t want;
		if (pin_q.size() == 0) begin
			report_error($sformatf("unexpected step: nibble %h rs %b en %b hold %0d last %b",
				lcd_data, reg_select, enable, hold, last));
		end else begin
			want = pin_q.pop_front();
			if (lcd_data !== want.nib)
				report_error($sformatf("lcd_data: expected %h, got %h", want.nib, lcd_data));
			if (reg_select !== want.rs)
				report_error($sformatf("reg_select: expected %b, got %b", want.rs, reg_select));
			if (enable !== want.en)
				report_error($sformatf("enable: expected %b, got %b", want.en, enable));
			if (hold !== want.hold)
				report_error($sformatf("hold: expected %0d, got %0d", want.hold, hold));
			if (last !== want.last)
				report_error($sformatf("last: expected %b, got %b", want.last, last));
		end
	endtask

	// Monitor: check each accepted step and stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_step();
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] val,
			input logic [WAIT_W-1:0] extra);
		lcd_req_t r;
		r.cmd   = cmd;
		r.val   = val;
		r.extra = extra;
		req_q.push_back(r);
	endtask

	function automatic logic [WAIT_W-1:0] pick_post_wait();
		logic [WAIT_W-1:0] w;
		case ($urandom_range(0, 7))
			0:       w = '0;
			1:       w = '1;
			default: w = WAIT_W'($urandom_range(0, 65535));
		endcase
		return w;
	endfunction

	// Register write; the block is idle whenever this is called.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PULSE_WIDTH: pulse_w = data[PW_W-1:0];
			REG_SETTLE_WAIT: settle_w = data[WAIT_W-1:0];
			default: begin
			end
		endcase
	endtask

	// Mostly a cursor instruction followed by a run of characters, some runs
	// long enough to wrap, plus init requests, bare runs and dropped codes.
	task automatic queue_random(input int quota);
		int made;
		int run_len;
		made = 0;
		while (made < quota) begin
			case ($urandom_range(0, 9))
				0: begin
					push_req(CMD_INIT, BYTE_W'($urandom), pick_post_wait());
					made++;
				end
				1: push_req(CMD_UNUSED, BYTE_W'($urandom), pick_post_wait());
				2: begin
					run_len = $urandom_range(1, 8);
					repeat (run_len) push_req(CMD_DATA, BYTE_W'($urandom), pick_post_wait());
					made += run_len;
				end
				default: begin
					push_req(CMD_INSTR, BYTE_W'($urandom), pick_post_wait());
					run_len = $urandom_range(1, 20);
					repeat (run_len) push_req(CMD_DATA, BYTE_W'($urandom), pick_post_wait());
					made += run_len + 1;
				end
			endcase
		end
	endtask

	// Hold the sender until every expected step is back and the block is quiet.
	task automatic drain_all();
		while (req_q.size() != 0 || in_valid || pin_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Main sequence: reset, directed items, then random phases.
	initial begin
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset timing, no idling: init, extreme instructions, a dropped code,
		// then a full row of characters that forces the wrap.
		idle_pct  = 0;
		stall_pct = 0;
		push_req(CMD_INIT, 8'hFF, 16'hFFFF);
		push_req(CMD_INSTR, 8'h00, 16'h0000);
		push_req(CMD_INSTR, 8'hFF, 16'hFFFF);
		push_req(CMD_UNUSED, 8'hA5, 16'h1234);
		push_req(CMD_DATA, 8'h00, 16'h0000);
		push_req(CMD_DATA, 8'hFF, 16'hFFFF);
		for (int i = 2; i < WRAP_COLUMN; i++)
			push_req(CMD_DATA, BYTE_W'($urandom), pick_post_wait());
		push_req(CMD_DATA, 8'h41, 16'd5);
		push_req(CMD_INSTR, 8'h01, 16'd0);
		queue_random(18);
		drain_all();

		// Widest timing, sender gaps; unmapped writes must change nothing.
		write_reg(REG_UNMAPPED_LO, 16'hFFFF);
		write_reg(REG_PULSE_WIDTH, 16'd1023);
		write_reg(REG_SETTLE_WAIT, 16'hFFFF);
		write_reg(REG_UNMAPPED_HI, 16'h0000);
		idle_pct  = 45;
		stall_pct = 0;
		push_req(CMD_DATA, 8'hFF, 16'hFFFF);
		queue_random(18);
		drain_all();

		// Zero pulse width and zero settle, receiver stalls.
		write_reg(REG_PULSE_WIDTH, 16'd0);
		write_reg(REG_SETTLE_WAIT, 16'd0);
		idle_pct  = 0;
		stall_pct = 45;
		push_req(CMD_INSTR, 8'h80, 16'd0);
		queue_random(18);
		drain_all();

		// Smallest nonzero pulse width with upper data bits set, random settle, both idle.
		write_reg(REG_PULSE_WIDTH, {6'h3F, 10'd1});
		write_reg(REG_SETTLE_WAIT, CFG_DATA_W'($urandom_range(0, 65535)));
		idle_pct  = 11;
		stall_pct = 11;
		queue_random(18);
		drain_all();

		if (err_count == 0)
			$display("char_lcd_nibble_writer_unit_test: done, clean");
		else
			$display("char_lcd_nibble_writer_unit_test: done, errors");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("timeout with %0d steps still expected", pin_q.size());
		$display("char_lcd_nibble_writer_unit_test: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
design/clnw_pkg.sv
design/clnw_front.sv
design/clnw_queue.sv
design/clnw_back.sv
design/char_lcd_nibble_writer_unit.sv
dv/char_lcd_nibble_writer_unit_test.sv
